// ===== rtl/core/hrlp_pkg.sv =====
// shared types, constants and name tables of the http request line parser
package hrlp_pkg;

  // field limits
  localparam int unsigned METHOD_LEN_MAX  = 8;
  localparam int unsigned URL_LEN_MAX     = 2048;
  localparam int unsigned VERSION_LEN_MAX = 8;

  localparam int unsigned MPOS_W    = $clog2(METHOD_LEN_MAX + 1);
  localparam int unsigned MIDX_W    = $clog2(METHOD_LEN_MAX);
  localparam int unsigned VPOS_W    = $clog2(VERSION_LEN_MAX + 1);
  localparam int unsigned VIDX_W    = $clog2(VERSION_LEN_MAX);
  localparam int unsigned URL_CNT_W = $clog2(URL_LEN_MAX + 1);

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // special bytes
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // result kinds and unknown codes
  localparam logic       KIND_URL_BYTE   = 1'b0;
  localparam logic       KIND_SUMMARY    = 1'b1;
  localparam logic [3:0] METHOD_UNKNOWN  = 4'd9;
  localparam logic [1:0] VERSION_UNKNOWN = 2'd3;

  // name tables, strings right-justified and zero-filled
  localparam int unsigned NAME_BYTES   = 16;
  localparam int unsigned NUM_METHODS  = 9;
  localparam int unsigned NUM_VERSIONS = 3;

  typedef logic [8*NAME_BYTES-1:0] name_str_t;

  localparam name_str_t METHOD_STR [NUM_METHODS] = '{
    "CONNECT", "DELETE", "GET", "HEAD", "OPTIONS", "PATCH", "POST", "PUT", "TRACE"
  };
  localparam int unsigned METHOD_STR_LEN [NUM_METHODS] = '{7, 6, 3, 4, 7, 5, 4, 3, 5};

  localparam name_str_t VERSION_STR [NUM_VERSIONS] = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2"};
  localparam int unsigned VERSION_STR_LEN [NUM_VERSIONS] = '{8, 8, 6};

  // operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_METHOD_CHAR,
    OP_URL_CHAR,
    OP_VERSION_CHAR,
    OP_SUMMARY
  } op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  url_byte;
    logic [3:0]  method_code;
    logic [1:0]  version_code;
    logic [11:0] url_length;
    logic        url_is_root;
    logic        method_overlong;
    logic        url_overlong;
    logic        version_overlong;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic       new_request;
  } op_t;

  // byte i of a right-justified name string, zero past its end
  function automatic logic [7:0] name_char(input name_str_t s, input int unsigned len,
                                           input int unsigned i);
    logic [7:0] c;
    if (i < len) begin
      c = s[8*(len-1-i) +: 8];
    end else begin
      c = 8'h00;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/hrlp_front.sv =====
// front part: tracks the parse phase and classifies each byte into an operation
module hrlp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hrlp_pkg::in_item_t in_item_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output hrlp_pkg::op_t     push_op_o
);
  import hrlp_pkg::*;

  typedef enum logic [1:0] {
    PH_METHOD,
    PH_URL,
    PH_VERSION,
    PH_DONE
  } phase_e;

  phase_e phase_q, phase_d, phase_cur;
  op_e    op;
  logic   accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  // new request restarts the line before this byte is classified
  always_comb begin
    phase_cur = in_item_i.new_request ? PH_METHOD : phase_q;
    phase_d   = phase_cur;
    op        = OP_NONE;
    case (phase_cur)
      PH_METHOD: begin
        if (in_item_i.data_byte == CHAR_SP) begin
          phase_d = PH_URL;
        end else begin
          op = OP_METHOD_CHAR;
        end
      end
      PH_URL: begin
        if (in_item_i.data_byte == CHAR_SP) begin
          phase_d = PH_VERSION;
        end else begin
          op = OP_URL_CHAR;
        end
      end
      PH_VERSION: begin
        if (in_item_i.data_byte == CHAR_CR) begin
          phase_d = PH_DONE;
          op      = OP_SUMMARY;
        end else begin
          op = OP_VERSION_CHAR;
        end
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  assign push_op_o = '{op: op, data_byte: in_item_i.data_byte,
                       new_request: in_item_i.new_request};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/core/hrlp_queue.sv =====
// short queue of operations between front and back
module hrlp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  hrlp_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output hrlp_pkg::op_t pop_op_o
);
  import hrlp_pkg::*;

  op_t               entries_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/hrlp_back.sv =====
// back part: field buffers, name matching and the output register
module hrlp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  hrlp_pkg::op_t      pop_op_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hrlp_pkg::out_item_t out_item_o
);
  import hrlp_pkg::*;

  logic [7:0]           meth_q [METHOD_LEN_MAX];
  logic [7:0]           meth_d [METHOD_LEN_MAX];
  logic [7:0]           ver_q  [VERSION_LEN_MAX];
  logic [7:0]           ver_d  [VERSION_LEN_MAX];
  logic [MPOS_W-1:0]    mpos_q, mpos_d;
  logic [VPOS_W-1:0]    vpos_q, vpos_d;
  logic [URL_CNT_W-1:0] url_cnt_q, url_cnt_d;
  logic [7:0]           first_q, first_d;
  logic [2:0]           marks_q, marks_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                   out_free, needs_out, pop;
  logic [NUM_METHODS-1:0]  meth_hit;
  logic [NUM_VERSIONS-1:0] ver_hit;
  logic [3:0]              mcode;
  logic [1:0]              vcode;
  logic [12:0]             url_cnt_ext;
  logic [11:0]             url_len;

  assign out_free    = !out_valid_q || out_ready_i;
  assign needs_out   = (pop_op_i.op == OP_URL_CHAR) || (pop_op_i.op == OP_SUMMARY);
  assign pop_ready_o = out_free || !needs_out;
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // compare zero-padded buffers with every name
  always_comb begin
    for (int k = 0; k < NUM_METHODS; k++) begin
      meth_hit[k] = 1'b1;
      for (int i = 0; i < METHOD_LEN_MAX; i++) begin
        if (meth_q[i] != name_char(METHOD_STR[k], METHOD_STR_LEN[k], i)) begin
          meth_hit[k] = 1'b0;
        end
      end
      for (int i = METHOD_LEN_MAX; i < NAME_BYTES; i++) begin
        if (name_char(METHOD_STR[k], METHOD_STR_LEN[k], i) != 8'h00) begin
          meth_hit[k] = 1'b0;
        end
      end
    end
    for (int k = 0; k < NUM_VERSIONS; k++) begin
      ver_hit[k] = 1'b1;
      for (int i = 0; i < VERSION_LEN_MAX; i++) begin
        if (ver_q[i] != name_char(VERSION_STR[k], VERSION_STR_LEN[k], i)) begin
          ver_hit[k] = 1'b0;
        end
      end
      for (int i = VERSION_LEN_MAX; i < NAME_BYTES; i++) begin
        if (name_char(VERSION_STR[k], VERSION_STR_LEN[k], i) != 8'h00) begin
          ver_hit[k] = 1'b0;
        end
      end
    end
  end

  // first match wins, overlong reads as unknown
  always_comb begin
    mcode = METHOD_UNKNOWN;
    if (!marks_q[0]) begin
      for (int k = NUM_METHODS - 1; k >= 0; k--) begin
        if (meth_hit[k]) begin
          mcode = 4'(k);
        end
      end
    end
    vcode = VERSION_UNKNOWN;
    if (!marks_q[2]) begin
      for (int k = NUM_VERSIONS - 1; k >= 0; k--) begin
        if (ver_hit[k]) begin
          vcode = 2'(k);
        end
      end
    end
    url_cnt_ext = 13'(url_cnt_q);
    url_len     = (url_cnt_ext > 13'd4095) ? 12'd4095 : url_cnt_ext[11:0];
  end

  always_comb begin
    meth_d      = meth_q;
    ver_d       = ver_q;
    mpos_d      = mpos_q;
    vpos_d      = vpos_q;
    url_cnt_d   = url_cnt_q;
    first_d     = first_q;
    marks_d     = marks_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (pop && pop_op_i.new_request) begin
      for (int i = 0; i < METHOD_LEN_MAX; i++) begin
        meth_d[i] = 8'h00;
      end
      for (int i = 0; i < VERSION_LEN_MAX; i++) begin
        ver_d[i] = 8'h00;
      end
      mpos_d    = '0;
      vpos_d    = '0;
      url_cnt_d = '0;
      first_d   = 8'h00;
      marks_d   = 3'b000;
    end

    if (pop) begin
      case (pop_op_i.op)
        OP_METHOD_CHAR: begin
          if (mpos_d < MPOS_W'(METHOD_LEN_MAX)) begin
            meth_d[mpos_d[MIDX_W-1:0]] = pop_op_i.data_byte;
            mpos_d = mpos_d + 1'b1;
          end else begin
            marks_d[0] = 1'b1;
          end
        end
        OP_URL_CHAR: begin
          if (url_cnt_d == URL_CNT_W'(URL_LEN_MAX)) begin
            marks_d[1] = 1'b1;
          end else begin
            if (url_cnt_d == '0) begin
              first_d = pop_op_i.data_byte;
            end
            url_cnt_d   = url_cnt_d + 1'b1;
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.item_kind = KIND_URL_BYTE;
            out_d.url_byte  = pop_op_i.data_byte;
          end
        end
        OP_VERSION_CHAR: begin
          if (vpos_d < VPOS_W'(VERSION_LEN_MAX)) begin
            ver_d[vpos_d[VIDX_W-1:0]] = pop_op_i.data_byte;
            vpos_d = vpos_d + 1'b1;
          end else begin
            marks_d[2] = 1'b1;
          end
        end
        OP_SUMMARY: begin
          out_valid_d            = 1'b1;
          out_d.item_kind        = KIND_SUMMARY;
          out_d.url_byte         = 8'h00;
          out_d.method_code      = mcode;
          out_d.version_code     = vcode;
          out_d.url_length       = url_len;
          out_d.url_is_root      = (url_cnt_q == URL_CNT_W'(1)) && (first_q == CHAR_SLASH)
                                   && !marks_q[1];
          out_d.method_overlong  = marks_q[0];
          out_d.url_overlong     = marks_q[1];
          out_d.version_overlong = marks_q[2];
        end
        default: begin
          out_d = out_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < METHOD_LEN_MAX; i++) begin
        meth_q[i] <= 8'h00;
      end
      for (int i = 0; i < VERSION_LEN_MAX; i++) begin
        ver_q[i] <= 8'h00;
      end
      mpos_q      <= '0;
      vpos_q      <= '0;
      url_cnt_q   <= '0;
      first_q     <= 8'h00;
      marks_q     <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      meth_q      <= meth_d;
      ver_q       <= ver_d;
      mpos_q      <= mpos_d;
      vpos_q      <= vpos_d;
      url_cnt_q   <= url_cnt_d;
      first_q     <= first_d;
      marks_q     <= marks_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/http_request_line_parser.sv =====
// top level of the http request line parser
//
// input channel: one byte of a request start line per item (data_byte, with
//   new_request set on the first byte of a new line to clear all parse state)
// output channel: one item per url byte as it arrives (item_kind 0), up to the
//   first 2048, then one summary item (item_kind 1) on the cr that ends the version
//   field; bytes after the summary give nothing until the next new_request
// throughput: one byte per cycle, sustained as long as out_ready_i is high
// datapath: phase classification at the input, then the operation queue, then
//   buffer update and name match in the back part, which drives the output
//   register
// a two-entry operation queue sits between the classifier and the back part;
//   when the receiver stalls, bytes that give no result still drain, and
//   in_ready_o drops only once the queue is full
// reset: phase back to method, field buffers and counters cleared, queue and
//   output register empty
module http_request_line_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hrlp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hrlp_pkg::out_item_t out_item_o
);
  import hrlp_pkg::*;

  // front to queue
  logic push_valid, push_ready;
  op_t  push_op;

  // queue to back
  logic pop_valid, pop_ready;
  op_t  pop_op;

  // byte classification and phase tracking
  hrlp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  // decouples the classifier from output stalls
  hrlp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  // buffers, name matching, summary build and output register
  hrlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_op_i    (pop_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of the http request line parser: directed table, then random lines
`timescale 1ns / 1ps

module tb;
  import hrlp_pkg::*;

  // run limits
  localparam int unsigned RAND_ITEMS   = 1250;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam longint      LIMIT_NS     = 5_000_000;
  localparam int unsigned CHAR_SLOTS   = 16;
  localparam int unsigned MAX_PRINTS   = 30;

  // method and version codes that the directed table types in
  localparam logic [3:0] M_GET    = 4'd2;
  localparam logic [1:0] V_HTTP11 = 2'd1;

  // where the predictor stands in the line
  typedef enum logic [1:0] {
    LINE_METHOD,
    LINE_URL,
    LINE_VERSION,
    LINE_DONE
  } line_phase_e;

  // one row of the directed table: a byte, and where obvious the result it gives
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  localparam out_item_t NO_WANT       = '0;
  localparam out_item_t WANT_SLASH    = '{KIND_URL_BYTE, CHAR_SLASH, 4'd0, 2'd0, 12'd0,
                                          1'b0, 1'b0, 1'b0, 1'b0};
  localparam out_item_t WANT_GET_ROOT = '{KIND_SUMMARY, 8'h00, M_GET, V_HTTP11, 12'd1,
                                          1'b1, 1'b0, 1'b0, 1'b0};
  localparam out_item_t WANT_EMPTY    = '{KIND_SUMMARY, 8'h00, METHOD_UNKNOWN, VERSION_UNKNOWN,
                                          12'd0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam out_item_t WANT_CR_BYTE  = '{KIND_URL_BYTE, CHAR_CR, 4'd0, 2'd0, 12'd0,
                                          1'b0, 1'b0, 1'b0, 1'b0};
  localparam out_item_t WANT_FF_BYTE  = '{KIND_URL_BYTE, 8'hFF, 4'd0, 2'd0, 12'd0,
                                          1'b0, 1'b0, 1'b0, 1'b0};
  localparam out_item_t WANT_TWO      = '{KIND_SUMMARY, 8'h00, METHOD_UNKNOWN, VERSION_UNKNOWN,
                                          12'd2, 1'b0, 1'b0, 1'b0, 1'b0};

  // "GET / HTTP/1.1" cr, trailing bytes ignored, empty fields, cr and 0xff inside the url
  localparam dir_row_t DIRECTED [26] = '{
    '{"G", 1'b1, 1'b0, NO_WANT}, '{"E", 1'b0, 1'b0, NO_WANT}, '{"T", 1'b0, 1'b0, NO_WANT},
    '{CHAR_SP, 1'b0, 1'b0, NO_WANT},
    '{CHAR_SLASH, 1'b0, 1'b1, WANT_SLASH},
    '{CHAR_SP, 1'b0, 1'b0, NO_WANT},
    '{"H", 1'b0, 1'b0, NO_WANT}, '{"T", 1'b0, 1'b0, NO_WANT}, '{"T", 1'b0, 1'b0, NO_WANT},
    '{"P", 1'b0, 1'b0, NO_WANT}, '{"/", 1'b0, 1'b0, NO_WANT}, '{"1", 1'b0, 1'b0, NO_WANT},
    '{".", 1'b0, 1'b0, NO_WANT}, '{"1", 1'b0, 1'b0, NO_WANT},
    '{CHAR_CR, 1'b0, 1'b1, WANT_GET_ROOT},
    '{8'hFF, 1'b0, 1'b0, NO_WANT}, '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{CHAR_SP, 1'b1, 1'b0, NO_WANT}, '{CHAR_SP, 1'b0, 1'b0, NO_WANT},
    '{CHAR_CR, 1'b0, 1'b1, WANT_EMPTY},
    '{8'h00, 1'b1, 1'b0, NO_WANT}, '{CHAR_SP, 1'b0, 1'b0, NO_WANT},
    '{CHAR_CR, 1'b0, 1'b1, WANT_CR_BYTE}, '{8'hFF, 1'b0, 1'b1, WANT_FF_BYTE},
    '{CHAR_SP, 1'b0, 1'b0, NO_WANT},
    '{CHAR_CR, 1'b0, 1'b1, WANT_TWO}
  };

  // name tables of the predictor, compared zero-padded
  string method_names [NUM_METHODS] = '{"CONNECT", "DELETE", "GET", "HEAD", "OPTIONS",
                                        "PATCH", "POST", "PUT", "TRACE"};
  string version_names [NUM_VERSIONS] = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2"};

  // dut ports, inputs all known from time zero
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // predictor state
  line_phase_e line_phase;
  logic [7:0]  meth_chars [CHAR_SLOTS];
  logic [7:0]  ver_chars [CHAR_SLOTS];
  int unsigned field_pos;
  int unsigned url_kept;
  logic [7:0]  url_first;
  logic [2:0]  long_marks;

  // results still owed by the dut, oldest first
  out_item_t   pending_results [$];
  logic [7:0]  line_q [$];

  int unsigned err_cnt      = 0;
  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned url_seen     = 0;
  int unsigned lines_seen   = 0;
  int unsigned roots_seen   = 0;
  int unsigned long_seen [3] = '{0, 0, 0};
  bit          send_burst   = 1'b0;
  bit          recv_burst   = 1'b0;
  bit          held         = 1'b0;

  http_request_line_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_line();
    line_phase = LINE_METHOD;
    foreach (meth_chars[i]) meth_chars[i] = 8'h00;
    foreach (ver_chars[i]) ver_chars[i] = 8'h00;
    field_pos  = 0;
    url_kept   = 0;
    url_first  = 8'h00;
    long_marks = 3'b000;
  endtask

  // zero-padded compare of a field buffer of cap bytes with a name
  function automatic bit name_hit(input logic [7:0] chars [CHAR_SLOTS], input int unsigned cap,
                                  input string nm);
    int unsigned span;
    logic [7:0]  a;
    logic [7:0]  w;
    span = (cap > 9) ? cap : 9;
    for (int unsigned i = 0; i < span; i++) begin
      a = (i < cap) ? chars[i] : 8'h00;
      w = (i < nm.len()) ? nm[i] : 8'h00;
      if (a != w) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the line state by one byte; has tells whether a result comes of it
  task automatic predict_byte(input in_item_t it, output bit has, output out_item_t r);
    logic [7:0]  b;
    int unsigned mc;
    int unsigned vc;
    b   = it.data_byte;
    has = 1'b0;
    r   = '0;
    if (it.new_request) clear_line();
    case (line_phase)
      LINE_METHOD: begin
        if (b == CHAR_SP) begin
          line_phase = LINE_URL;
          field_pos  = 0;
        end else if (field_pos < METHOD_LEN_MAX) begin
          meth_chars[field_pos] = b;
          field_pos++;
        end else begin
          long_marks[0] = 1'b1;
        end
      end
      LINE_URL: begin
        if (b == CHAR_SP) begin
          line_phase = LINE_VERSION;
          field_pos  = 0;
        end else if (url_kept >= URL_LEN_MAX) begin
          // extra url bytes are dropped, not passed out
          long_marks[1] = 1'b1;
        end else begin
          if (url_kept == 0) url_first = b;
          url_kept++;
          has         = 1'b1;
          r.item_kind = KIND_URL_BYTE;
          r.url_byte  = b;
        end
      end
      LINE_VERSION: begin
        if (b != CHAR_CR) begin
          // spaces count as version bytes here
          if (field_pos < VERSION_LEN_MAX) begin
            ver_chars[field_pos] = b;
            field_pos++;
          end else begin
            long_marks[2] = 1'b1;
          end
        end else begin
          // cr ends the line: build the summary
          line_phase = LINE_DONE;
          mc = 32'(METHOD_UNKNOWN);
          if (!long_marks[0]) begin
            for (int unsigned k = 0; k < NUM_METHODS; k++) begin
              if (mc == 32'(METHOD_UNKNOWN) &&
                  name_hit(meth_chars, METHOD_LEN_MAX, method_names[k]))
                mc = k;
            end
          end
          vc = 32'(VERSION_UNKNOWN);
          if (!long_marks[2]) begin
            for (int unsigned k = 0; k < NUM_VERSIONS; k++) begin
              if (vc == 32'(VERSION_UNKNOWN) &&
                  name_hit(ver_chars, VERSION_LEN_MAX, version_names[k]))
                vc = k;
            end
          end
          has                = 1'b1;
          r.item_kind        = KIND_SUMMARY;
          r.method_code      = mc[3:0];
          r.version_code     = vc[1:0];
          r.url_length       = (url_kept > 4095) ? 12'd4095 : url_kept[11:0];
          r.url_is_root      = (url_kept == 1 && url_first == CHAR_SLASH && !long_marks[1]);
          r.method_overlong  = long_marks[0];
          r.url_overlong     = long_marks[1];
          r.version_overlong = long_marks[2];
        end
      end
      default: ;  // bytes after the summary wait for new_request
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // sender: one byte item per call, idle gap first, then hold until accepted
  // ---------------------------------------------------------------------------

  task automatic send_byte(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    bit          has;
    out_item_t   r;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    predict_byte(it, has, r);
    if (has) pending_results.push_back(typed ? want : r);
  endtask

  function automatic logic [7:0] rand_byte_not(input logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == avoid);
    return c;
  endfunction

  // one random start line into line_q; url_force picks a fixed url length
  task automatic build_line(input int unsigned url_force);
    int unsigned pick;
    int unsigned n;
    string       nm;
    line_q.delete();

    // method: mostly known names, some random, some too long, some empty
    pick = $urandom_range(0, 9);
    if (pick <= 6) begin
      nm = method_names[$urandom_range(0, NUM_METHODS - 1)];
      for (int i = 0; i < nm.len(); i++) line_q.push_back(nm[i]);
      // a trailing zero byte must not spoil the match
      if ($urandom_range(0, 9) == 0) line_q.push_back(8'h00);
    end else begin
      n = (pick == 7) ? $urandom_range(1, METHOD_LEN_MAX) :
          (pick == 8) ? $urandom_range(METHOD_LEN_MAX + 1, METHOD_LEN_MAX + 4) : 0;
      repeat (n) line_q.push_back(rand_byte_not(CHAR_SP));
    end
    line_q.push_back(CHAR_SP);

    // url: exact root, empty, or a short path; cr and zero are plain bytes here
    if (url_force != 0) begin
      n = url_force;
    end else begin
      pick = $urandom_range(0, 19);
      n = (pick <= 2) ? 1 : (pick == 3) ? 0 : $urandom_range(1, 24);
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0 && $urandom_range(0, 9) < 8) line_q.push_back(CHAR_SLASH);
      else line_q.push_back(rand_byte_not(CHAR_SP));
    end
    line_q.push_back(CHAR_SP);

    // version: known names, random, too long, or empty
    pick = $urandom_range(0, 9);
    if (pick <= 6) begin
      nm = version_names[$urandom_range(0, NUM_VERSIONS - 1)];
      for (int i = 0; i < nm.len(); i++) line_q.push_back(nm[i]);
      if (nm.len() < VERSION_LEN_MAX && $urandom_range(0, 4) == 0) line_q.push_back(8'h00);
    end else begin
      n = (pick == 7) ? $urandom_range(1, VERSION_LEN_MAX) :
          (pick == 8) ? $urandom_range(VERSION_LEN_MAX + 1, VERSION_LEN_MAX + 3) : 0;
      repeat (n) line_q.push_back(rand_byte_not(CHAR_CR));
    end

    // ending: mostly cr, now and then trailing junk, sometimes cut short
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, line_q.size());
      repeat (n) void'(line_q.pop_back());
    end else begin
      line_q.push_back(CHAR_CR);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off, compare against the oldest result
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("tb: mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string fname, input logic [11:0] got,
                             input logic [11:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, fname,
                                got, want));
  endtask

  initial begin : receiver
    int unsigned gap;
    out_item_t   got;
    out_item_t   want;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = recv_burst ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = out_item_o;
      results_seen++;
      if (results_seen % 64 == 0) recv_burst = !recv_burst;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("item_kind",        12'(got.item_kind),        12'(want.item_kind));
        check_field("url_byte",         12'(got.url_byte),         12'(want.url_byte));
        check_field("method_code",      12'(got.method_code),      12'(want.method_code));
        check_field("version_code",     12'(got.version_code),     12'(want.version_code));
        check_field("url_length",       got.url_length,            want.url_length);
        check_field("url_is_root",      12'(got.url_is_root),      12'(want.url_is_root));
        check_field("method_overlong",  12'(got.method_overlong),
                    12'(want.method_overlong));
        check_field("url_overlong",     12'(got.url_overlong),     12'(want.url_overlong));
        check_field("version_overlong", 12'(got.version_overlong),
                    12'(want.version_overlong));
        if (want.item_kind == KIND_SUMMARY) begin
          lines_seen++;
          if (want.url_is_root) roots_seen++;
          if (want.method_overlong) long_seen[0]++;
          if (want.url_overlong) long_seen[1]++;
          if (want.version_overlong) long_seen[2]++;
        end else begin
          url_seen++;
        end
      end
      // long hold-off while the sender keeps offering: queue fills, input stalls
      if (!held && results_seen == HOLD_AT) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    in_item_t    it;
    int unsigned rand_bytes;
    int unsigned req;
    int unsigned url_force;
    bit          noise;
    clear_line();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DIRECTED[i]) begin
      it.data_byte   = DIRECTED[i].data_byte;
      it.new_request = DIRECTED[i].new_request;
      send_byte(it, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // random lines; two long urls hit the url limit exactly and just past it
    rand_bytes = 0;
    req        = 0;
    while (rand_bytes < RAND_ITEMS) begin
      url_force = (req == 4) ? URL_LEN_MAX : (req == 9) ? URL_LEN_MAX + 3 : 0;
      noise     = (url_force == 0 && $urandom_range(0, 19) == 0);
      if (noise) begin
        line_q.delete();
        repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_line(url_force);
      end
      foreach (line_q[i]) begin
        it.data_byte   = line_q[i];
        it.new_request = noise ? 1'($urandom_range(0, 1)) : (i == 0);
        send_byte(it, 1'b0, NO_WANT);
      end
      if (url_force == 0) rand_bytes += line_q.size();
      req++;
      if (req % 40 == 0) send_burst = !send_burst;
    end
    in_valid_i <= 1'b0;

    // drain, then a few more cycles to catch stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d bytes in, %0d url bytes and %0d line summaries (%0d root) compared",
             bytes_sent, url_seen, lines_seen, roots_seen);
    $display("tb: too-long fields seen: method %0d, url %0d, version %0d; %0d mismatches",
             long_seen[0], long_seen[1], long_seen[2], err_cnt);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
